// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GSB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("graph store assertion failed");

// antecedent implies consequent in the next cycle
`define GSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("graph store assertion failed");

`endif

// ===== rtl/gsb_pkg.sv =====
// ----------------------------------------------------------------------------
// gsb_pkg
// Types, codes and controller/datapath interface structs of the graph store.
// ----------------------------------------------------------------------------
package gsb_pkg;

	localparam int NODE_W = 6;
	localparam int DIST_W = 6;
	localparam int ACT_W  = 3;
	localparam int STS_W  = 3;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [DIST_W-1:0] dist_t;

	// register index on the config port (paddr[2])
	localparam logic CFG_IDX_MAX_DIST = 1'b0;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD_NODE = 3'd0,
		ACT_REM_NODE = 3'd1,
		ACT_ADD_EDGE = 3'd2,
		ACT_REM_EDGE = 3'd3,
		ACT_QUERY    = 3'd4,
		ACT_CLEAR    = 3'd5
	} action_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK      = 3'd0,
		STS_MISSING = 3'd1,
		STS_SELF    = 3'd2,
		STS_EXISTS  = 3'd3,
		STS_NO_EDGE = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_EDGE_CHK,
		S_EDGE_WRB,
		S_SW_RD,
		S_SW_WR,
		S_EMIT,
		S_Q_RD,
		S_Q_EXP,
		S_Q_NB,
		S_Q_ENQ,
		S_Q_OUT
	} state_t;

	// adjacency row read address select
	typedef enum logic [1:0] {
		RS_A,
		RS_B,
		RS_SWEEP,
		RS_CUR
	} row_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     row_rd;
		row_sel_t row_sel;
		logic     row_wr;
		logic     wr_set;    // 1: set bit, 0: clear bit
		logic     wr_bit_b;  // 1: bit index node_b, 0: node_a
		logic     node_set;
		logic     node_drop;
		logic     graph_clr;
		logic     sw_clr;
		logic     sw_inc;
		logic     q_init;
		logic     q_rd;
		logic     nb_load;
		logic     enq;
		logic     emit_cfg;  // single result of a non-query action or a refused query
		logic     emit_q;    // one query result
		status_t  status;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic a_in;
		logic b_in;
		logic a_present;
		logic b_present;
		logic a_eq_b;
		logic adj_ab;
		logic sw_done;
		logic dist_limit;
		logic nb_empty;
		logic q_empty;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/graph_store_depth_limited_bfs.sv =====
// ----------------------------------------------------------------------------
// graph_store_depth_limited_bfs
// Undirected graph store with node and edge actions and a depth-limited
// breadth-first reachability query.
// ----------------------------------------------------------------------------
// One action item is taken at a time; s_axis_tready is high only while the
// sequencer is idle, and the result register lets the next item in while the
// last result still waits. Add node, clear and actions refused at decode go
// from decode straight to the result; an edge action refused at the row check
// goes on to the result from there, and edge updates do one read and write of
// each end's adjacency row. Remove node sweeps every adjacency row, one row at
// a time, to drop the node's column. A query reads each reached node from the
// queue; below max_distance it then reads the node's adjacency row and queues
// each newly found neighbor, one at a time, before its result leaves. Results
// leave in search order, neighbors in ascending index order, the last one
// marked with m_axis_tlast. Node indexes at or above MAX_NODES count as
// missing nodes; a remove edge naming one is refused as no edge.
module graph_store_depth_limited_bfs
	import gsb_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// action items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // node_a [5:0], node_b [11:6], zero [15:12]
	input  logic [2:0]  s_axis_tuser,   // action [2:0]
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // node_id [5:0], distance [11:6], zero [15:12]
	output logic [2:0]  m_axis_tuser,   // status [2:0]
	output logic        m_axis_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dist_t max_distance_q;
	cmd_t  cmd;
	stat_t st;
	node_t out_node;
	dist_t out_dist;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= DIST_W'(2);
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == CFG_IDX_MAX_DIST)) begin
			max_distance_q <= pwdata[DIST_W-1:0];
		end
	end

	assign prdata = (paddr[2] == CFG_IDX_MAX_DIST) ? 32'(max_distance_q) : '0;

	gsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	gsb_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_action    (s_axis_tuser),
		.in_node_a    (s_axis_tdata[5:0]),
		.in_node_b    (s_axis_tdata[11:6]),
		.max_distance (max_distance_q),
		.cmd          (cmd),
		.st           (st),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_node_id  (out_node),
		.out_distance (out_dist),
		.out_status   (m_axis_tuser),
		.out_last     (m_axis_tlast)
	);

	assign m_axis_tdata = {4'b0000, out_dist, out_node};

endmodule

// ===== rtl/gsb_datapath.sv =====
// ----------------------------------------------------------------------------
// gsb_datapath
// Node mask, adjacency row memory, search queue memory, visited mask and the
// result register of the graph store.
// ----------------------------------------------------------------------------
module gsb_datapath
	import gsb_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [ACT_W-1:0] in_action,
	input  node_t       in_node_a,
	input  node_t       in_node_b,
	input  dist_t       max_distance,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic        out_ready,
	output logic        out_valid,
	output node_t       out_node_id,
	output dist_t       out_distance,
	output logic [STS_W-1:0] out_status,
	output logic        out_last
);

	localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int PTR_W = IDX_W + 1;
	localparam logic [NODE_W:0]    NODE_LIM = (NODE_W+1)'(MAX_NODES);
	localparam logic [MAX_NODES-1:0] ONE    = MAX_NODES'(1);

	typedef struct packed {
		dist_t hops;
		node_t node;
	} qent_t;

	logic [ACT_W-1:0] act_q;
	node_t            a_q;
	node_t            b_q;

	logic [MAX_NODES-1:0] node_valid_q;
	logic [MAX_NODES-1:0] row_valid_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] nb_q;

	logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
	logic [MAX_NODES-1:0] row_rd_q;
	logic                 row_v_q;
	logic [IDX_W-1:0]     row_addr_q;

	qent_t            q_mem [MAX_NODES];
	qent_t            ent_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] sw_q;

	logic             out_valid_q;
	node_t            out_node_q;
	dist_t            out_dist_q;
	logic [STS_W-1:0] out_status_q;
	logic             out_last_q;

	logic [IDX_W-1:0]     a_idx;
	logic [IDX_W-1:0]     b_idx;
	logic [IDX_W-1:0]     rd_addr;
	logic [IDX_W-1:0]     wr_bit_idx;
	logic [MAX_NODES-1:0] eff_row;
	logic [MAX_NODES-1:0] wr_mask;
	logic [MAX_NODES-1:0] wr_data;
	logic [MAX_NODES-1:0] low_bit;
	logic [IDX_W-1:0]     low_idx;
	logic                 q_we;
	logic [IDX_W-1:0]     q_waddr;
	qent_t                q_wdata;
	logic                 a_in;
	logic                 b_in;
	logic                 out_free;

	assign a_idx = a_q[IDX_W-1:0];
	assign b_idx = b_q[IDX_W-1:0];
	assign a_in  = {1'b0, a_q} < NODE_LIM;
	assign b_in  = {1'b0, b_q} < NODE_LIM;

	// a row never written since reset or clear reads as empty
	assign eff_row = row_v_q ? row_rd_q : '0;

	always_comb begin
		case (cmd.row_sel)
			RS_A:     rd_addr = a_idx;
			RS_B:     rd_addr = b_idx;
			RS_SWEEP: rd_addr = sw_q[IDX_W-1:0];
			RS_CUR:   rd_addr = ent_q.node[IDX_W-1:0];
			default:  rd_addr = a_idx;
		endcase
	end

	assign wr_bit_idx = cmd.wr_bit_b ? b_idx : a_idx;
	assign wr_mask    = ONE << wr_bit_idx;
	assign wr_data    = cmd.wr_set ? (eff_row | wr_mask) : (eff_row & ~wr_mask);

	// lowest pending neighbor
	assign low_bit = nb_q & (~nb_q + ONE);
	always_comb begin
		low_idx = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (low_bit[i])
				low_idx = low_idx | IDX_W'(i);
		end
	end

	assign q_we    = cmd.q_init | cmd.enq;
	assign q_waddr = cmd.q_init ? '0 : tail_q[IDX_W-1:0];
	always_comb begin
		if (cmd.q_init) begin
			q_wdata.hops = '0;
			q_wdata.node = a_q;
		end else begin
			q_wdata.hops = ent_q.hops + DIST_W'(1);
			q_wdata.node = node_t'(low_idx);
		end
	end

	// input item and memories
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= in_action;
			a_q   <= in_node_a;
			b_q   <= in_node_b;
		end
		if (cmd.row_wr)
			adj_mem[row_addr_q] <= wr_data;
		if (cmd.row_rd) begin
			row_rd_q   <= adj_mem[rd_addr];
			row_v_q    <= row_valid_q[rd_addr];
			row_addr_q <= rd_addr;
		end
		if (q_we)
			q_mem[q_waddr] <= q_wdata;
		if (cmd.q_rd)
			ent_q <= q_mem[head_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_valid_q <= '0;
			row_valid_q  <= '0;
			visited_q    <= '0;
			nb_q         <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			sw_q         <= '0;
		end else begin
			if (cmd.graph_clr) begin
				node_valid_q <= '0;
				row_valid_q  <= '0;
			end
			if (cmd.node_set)
				node_valid_q[a_idx] <= 1'b1;
			if (cmd.row_wr)
				row_valid_q[row_addr_q] <= 1'b1;
			// dropping a node wins over the sweep's last row write
			if (cmd.node_drop) begin
				node_valid_q[a_idx] <= 1'b0;
				row_valid_q[a_idx]  <= 1'b0;
			end
			if (cmd.sw_clr)
				sw_q <= '0;
			else if (cmd.sw_inc)
				sw_q <= sw_q + PTR_W'(1);
			if (cmd.q_init) begin
				visited_q <= ONE << a_idx;
				head_q    <= '0;
				tail_q    <= PTR_W'(1);
			end else begin
				if (cmd.q_rd)
					head_q <= head_q + PTR_W'(1);
				if (cmd.enq) begin
					visited_q <= visited_q | low_bit;
					tail_q    <= tail_q + PTR_W'(1);
				end
			end
			if (cmd.nb_load)
				nb_q <= eff_row & node_valid_q & ~visited_q;
			else if (cmd.enq)
				nb_q <= nb_q & ~low_bit;
		end
	end

	// result register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_cfg || cmd.emit_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_cfg) begin
			out_node_q   <= '0;
			out_dist_q   <= '0;
			out_status_q <= cmd.status;
			out_last_q   <= 1'b1;
		end else if (cmd.emit_q) begin
			out_node_q   <= ent_q.node;
			out_dist_q   <= ent_q.hops;
			out_status_q <= STS_OK;
			out_last_q   <= (head_q == tail_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_node_id  = out_node_q;
	assign out_distance = out_dist_q;
	assign out_status   = out_status_q;
	assign out_last     = out_last_q;

	always_comb begin
		st.act        = act_q;
		st.a_in       = a_in;
		st.b_in       = b_in;
		st.a_present  = a_in && node_valid_q[a_idx];
		st.b_present  = b_in && node_valid_q[b_idx];
		st.a_eq_b     = (a_q == b_q);
		st.adj_ab     = eff_row[b_idx];
		st.sw_done    = (sw_q == PTR_W'(MAX_NODES));
		st.dist_limit = (ent_q.hops >= max_distance);
		st.nb_empty   = (nb_q == '0);
		st.q_empty    = (head_q == tail_q);
		st.out_free   = out_free;
	end

endmodule

// ===== rtl/gsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsb_ctrl
// Sequencer of the graph store: decodes each action item and steps the
// datapath through row updates, the node removal sweep and the search.
// ----------------------------------------------------------------------------
module gsb_ctrl
	import gsb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t  state_q, state_d;
	status_t status_q, status_d;
	logic    is_add;

	assign is_add = (st.act == ACT_ADD_EDGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= STS_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d  = S_EMIT;
				status_d = STS_OK;
				case (st.act)
					ACT_ADD_NODE: begin
						if (!st.a_in)
							status_d = STS_MISSING;
						else if (st.a_present)
							status_d = STS_EXISTS;
					end
					ACT_REM_NODE: begin
						if (!st.a_present)
							status_d = STS_MISSING;
						else
							state_d = S_SW_RD;
					end
					ACT_ADD_EDGE: begin
						if (!st.a_present || !st.b_present)
							status_d = STS_MISSING;
						else if (st.a_eq_b)
							status_d = STS_SELF;
						else
							state_d = S_EDGE_CHK;
					end
					ACT_REM_EDGE: begin
						if (!st.a_in || !st.b_in || st.a_eq_b)
							status_d = STS_NO_EDGE;
						else
							state_d = S_EDGE_CHK;
					end
					ACT_QUERY: begin
						if (!st.a_present)
							status_d = STS_MISSING;
						else
							state_d = S_Q_RD;
					end
					ACT_CLEAR: begin
						status_d = STS_OK;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_EDGE_CHK: begin
				if (is_add && st.adj_ab) begin
					status_d = STS_EXISTS;
					state_d  = S_EMIT;
				end else if (!is_add && !st.adj_ab) begin
					status_d = STS_NO_EDGE;
					state_d  = S_EMIT;
				end else begin
					state_d = S_EDGE_WRB;
				end
			end
			S_EDGE_WRB: state_d = S_EMIT;
			S_SW_RD:    state_d = S_SW_WR;
			S_SW_WR: begin
				if (st.sw_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free)
					state_d = S_IDLE;
			end
			S_Q_RD: state_d = S_Q_EXP;
			S_Q_EXP: begin
				state_d = st.dist_limit ? S_Q_OUT : S_Q_NB;
			end
			S_Q_NB: state_d = S_Q_ENQ;
			S_Q_ENQ: begin
				if (st.nb_empty)
					state_d = S_Q_OUT;
			end
			S_Q_OUT: begin
				if (st.out_free)
					state_d = st.q_empty ? S_IDLE : S_Q_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		cmd.status = status_q;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_DECODE: begin
				case (st.act)
					ACT_ADD_NODE: begin
						cmd.node_set = st.a_in && !st.a_present;
					end
					ACT_REM_NODE: begin
						cmd.sw_clr = 1'b1;
					end
					ACT_ADD_EDGE: begin
						cmd.row_rd  = st.a_present && st.b_present && !st.a_eq_b;
						cmd.row_sel = RS_A;
					end
					ACT_REM_EDGE: begin
						cmd.row_rd  = st.a_in && st.b_in && !st.a_eq_b;
						cmd.row_sel = RS_A;
					end
					ACT_QUERY: begin
						cmd.q_init = st.a_present;
					end
					ACT_CLEAR: begin
						cmd.graph_clr = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_EDGE_CHK: begin
				if (is_add != st.adj_ab) begin
					// row a gets bit b, and row b is fetched
					cmd.row_wr   = 1'b1;
					cmd.wr_set   = is_add;
					cmd.wr_bit_b = 1'b1;
					cmd.row_rd   = 1'b1;
					cmd.row_sel  = RS_B;
				end
			end
			S_EDGE_WRB: begin
				cmd.row_wr   = 1'b1;
				cmd.wr_set   = is_add;
				cmd.wr_bit_b = 1'b0;
			end
			S_SW_RD: begin
				cmd.row_rd  = 1'b1;
				cmd.row_sel = RS_SWEEP;
				cmd.sw_inc  = 1'b1;
			end
			S_SW_WR: begin
				// clear column a of the row fetched last, fetch the next one
				cmd.row_wr  = 1'b1;
				cmd.row_sel = RS_SWEEP;
				if (st.sw_done) begin
					cmd.node_drop = 1'b1;
				end else begin
					cmd.row_rd = 1'b1;
					cmd.sw_inc = 1'b1;
				end
			end
			S_EMIT: begin
				cmd.emit_cfg = st.out_free;
			end
			S_Q_RD: begin
				cmd.q_rd = 1'b1;
			end
			S_Q_EXP: begin
				cmd.row_rd  = !st.dist_limit;
				cmd.row_sel = RS_CUR;
			end
			S_Q_NB: begin
				cmd.nb_load = 1'b1;
			end
			S_Q_ENQ: begin
				cmd.enq = !st.nb_empty;
			end
			S_Q_OUT: begin
				cmd.emit_q = st.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/gsb_checker.sv =====
// ----------------------------------------------------------------------------
// gsb_checker
// Port-level checks of the graph store, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsb_checker
	import gsb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled result holds
	`GSB_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

	// one item in work at a time
	`GSB_ASSERT_NEXT(a_one_item, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	`GSB_ASSERT_SAME(a_status_code, clk, arst_n, m_axis_tvalid, m_axis_tuser == STS_OK || m_axis_tuser == STS_MISSING || m_axis_tuser == STS_SELF || m_axis_tuser == STS_EXISTS || m_axis_tuser == STS_NO_EDGE)

	// a refused action gives a single empty result
	`GSB_ASSERT_SAME(a_fail_single, clk, arst_n, m_axis_tvalid && (m_axis_tuser != STS_OK), m_axis_tlast && (m_axis_tdata == 16'h0000))

endmodule

bind graph_store_depth_limited_bfs gsb_checker u_gsb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb_graph_store_depth_limited_bfs.sv =====
// ----------------------------------------------------------------------------
// tb_graph_store_depth_limited_bfs
// Drives random graph edit and reachability query items into the graph store
// and checks every result against a built-in graph and breadth-first search
// predictor, over several search depth settings.
// ----------------------------------------------------------------------------
module tb_graph_store_depth_limited_bfs
	import gsb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 64;
	localparam logic [ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_UNUSED_7 = 3'd7;
	localparam dist_t DIST_MIN = 6'd0;
	localparam dist_t DIST_ONE = 6'd1;
	localparam dist_t DIST_RESET = 6'd2;
	localparam dist_t DIST_MAX = 6'd63;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS = 68;

	typedef struct packed {
		node_t   node_id;
		dist_t   distance;
		status_t status;
		logic    last;
	} hop_result_t;

	// Graph shadow plus the queue of results still owed by the block
	class bfs_scoreboard;
		logic [63:0] node_valid;
		logic [63:0] adj [64];
		dist_t       max_dist;
		hop_result_t awaited [$];
		int          fails;

		function new();
			node_valid = '0;
			foreach (adj[i]) adj[i] = '0;
			max_dist = DIST_RESET;
			fails = 0;
		endfunction

		function void push(node_t n, dist_t d, status_t s, logic l);
			hop_result_t r;
			r.node_id = n;
			r.distance = d;
			r.status = s;
			r.last = l;
			awaited.push_back(r);
		endfunction

		function void search(node_t start);
			node_t       q_node [64];
			dist_t       q_dist [64];
			logic [63:0] seen;
			logic [63:0] nb;
			int          head;
			int          tail;
			int          i;
			if (!node_valid[start]) begin
				push('0, '0, STS_MISSING, 1'b1);
				return;
			end
			seen = 64'd1 << start;
			q_node[0] = start;
			q_dist[0] = '0;
			head = 0;
			tail = 1;
			while (head < tail) begin
				if (q_dist[head] < max_dist) begin
					nb = adj[q_node[head]] & node_valid & ~seen;
					for (i = 0; i < NODES; i++) begin
						if (nb[i] && tail < NODES) begin
							seen[i] = 1'b1;
							q_node[tail] = node_t'(i);
							q_dist[tail] = q_dist[head] + 1'b1;
							tail++;
						end
					end
				end
				head++;
			end
			// results leave in dequeue order
			for (i = 0; i < tail; i++)
				push(q_node[i], q_dist[i], STS_OK, i == tail - 1);
		endfunction

		function void note_input(logic [ACT_W-1:0] act, node_t a, node_t b);
			status_t st;
			int      i;
			st = STS_OK;
			case (act)
			ACT_ADD_NODE: begin
				if (node_valid[a]) st = STS_EXISTS;
				else begin
					node_valid[a] = 1'b1;
					adj[a] = '0;
				end
			end
			ACT_REM_NODE: begin
				if (!node_valid[a]) st = STS_MISSING;
				else begin
					for (i = 0; i < NODES; i++) adj[i][a] = 1'b0;
					adj[a] = '0;
					node_valid[a] = 1'b0;
				end
			end
			ACT_ADD_EDGE: begin
				if (!node_valid[a] || !node_valid[b]) st = STS_MISSING;
				else if (a == b) st = STS_SELF;
				else if (adj[a][b]) st = STS_EXISTS;
				else begin
					adj[a][b] = 1'b1;
					adj[b][a] = 1'b1;
				end
			end
			ACT_REM_EDGE: begin
				if (a == b || !adj[a][b]) st = STS_NO_EDGE;
				else begin
					adj[a][b] = 1'b0;
					adj[b][a] = 1'b0;
				end
			end
			ACT_QUERY: begin
				search(a);
				return;
			end
			ACT_CLEAR: begin
				node_valid = '0;
				foreach (adj[i]) adj[i] = '0;
			end
			default: begin
				return;
			end
			endcase
			push('0, '0, st, 1'b1);
		endfunction

		function void flag(string field, logic [5:0] want_v, logic [5:0] got_v);
			$display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
			fails++;
		endfunction

		function void check(node_t n, dist_t d, logic [STS_W-1:0] s, logic l);
			hop_result_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result with none awaited: node %0d distance %0d status %0d last %0b",
					$time, n, d, s, l);
				fails++;
				return;
			end
			want = awaited.pop_front();
			if (n !== want.node_id) flag("node_id", want.node_id, n);
			if (d !== want.distance) flag("distance", want.distance, d);
			if (s !== want.status) flag("status", want.status, s);
			if (l !== want.last) flag("last", want.last, l);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // node_a [5:0], node_b [11:6], zero [15:12]
	logic [2:0]  s_axis_tuser = '0;   // action [2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // node_id [5:0], distance [11:6], zero [15:12]
	logic [2:0]  m_axis_tuser;        // status [2:0]
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	bfs_scoreboard sb;
	int            burst_left = 0;
	int            items_sent = 0;
	int            pool_base = 0;
	int            pool_span = NODES;
	int            stall_left = 0;
	logic [15:0]   ready_pattern = '1;

	graph_store_depth_limited_bfs DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: rotating ready pattern, reloaded now and then
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(16, 96);
			case ($urandom_range(0, 2))
			0: ready_pattern = '1;
			1: ready_pattern = 16'($urandom) | 16'h0001;
			default: ready_pattern = 16'h0001 << $urandom_range(0, 15);
			endcase
		end
		stall_left--;
		m_axis_tready <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tuser, m_axis_tlast);
	end

	task automatic send_item(input logic [ACT_W-1:0] act, input node_t a, input node_t b);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {4'b0000, b, a};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		sb.note_input(act, a, b);
		if (act <= ACT_CLEAR) items_sent++;
	endtask

	// wait out every owed result, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input dist_t value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {CFG_IDX_MAX_DIST, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.max_dist = value;
		@(posedge clk);
	endtask

	task automatic apb_check_read();
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= {CFG_IDX_MAX_DIST, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== 32'(sb.max_dist)) begin
			$display("%0t: max_distance readback expected %0d, got %0d",
				$time, sb.max_dist, prdata);
			sb.fails++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic node_t pick_node();
		return node_t'(pool_base + $urandom_range(0, pool_span - 1));
	endfunction

	// mostly edits and queries inside a small node window, some raw noise
	task automatic random_item();
		int    r;
		int    nxt;
		node_t a;
		node_t b;
		r = $urandom_range(0, 99);
		a = pick_node();
		b = pick_node();
		nxt = int'(a) + 1;
		if ($urandom_range(0, 1)) b = node_t'((nxt < pool_base + pool_span) ? nxt : pool_base);
		if (r < 22) send_item(ACT_ADD_NODE, a, b);
		else if (r < 55) send_item(ACT_ADD_EDGE, a, b);
		else if (r < 75) send_item(ACT_QUERY, a, b);
		else if (r < 84) send_item(ACT_REM_EDGE, a, b);
		else if (r < 91) send_item(ACT_REM_NODE, a, b);
		else if (r < 93) send_item(ACT_CLEAR, a, b);
		else send_item(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63)));
	endtask

	initial begin
		int    spans [6];
		int    ph;
		int    start_count;
		dist_t md;
		spans = '{8, 12, 16, 4, 32, 64};
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_check_read();

		// directed part at the reset depth
		send_item(ACT_ADD_NODE, 6'd0, 6'd0);
		send_item(ACT_ADD_NODE, 6'd63, 6'd63);
		send_item(ACT_ADD_NODE, 6'd0, 6'd63);      // already present
		send_item(ACT_REM_NODE, 6'd5, 6'd0);       // not present
		send_item(ACT_ADD_EDGE, 6'd0, 6'd63);
		send_item(ACT_ADD_EDGE, 6'd63, 6'd0);      // already there
		send_item(ACT_ADD_EDGE, 6'd0, 6'd0);       // self edge
		send_item(ACT_ADD_EDGE, 6'd0, 6'd5);       // missing end
		send_item(ACT_ADD_NODE, 6'd1, 6'd0);
		send_item(ACT_ADD_NODE, 6'd2, 6'd0);
		send_item(ACT_ADD_NODE, 6'd3, 6'd0);
		send_item(ACT_ADD_EDGE, 6'd0, 6'd1);
		send_item(ACT_ADD_EDGE, 6'd1, 6'd2);
		send_item(ACT_ADD_EDGE, 6'd2, 6'd3);
		send_item(ACT_QUERY, 6'd0, 6'd0);          // node 3 lies past the limit
		send_item(ACT_QUERY, 6'd5, 6'd0);          // start missing
		send_item(ACT_REM_EDGE, 6'd0, 6'd0);
		send_item(ACT_REM_EDGE, 6'd2, 6'd3);
		send_item(ACT_REM_EDGE, 6'd2, 6'd3);       // gone already
		send_item(ACT_REM_NODE, 6'd1, 6'd0);       // drops its edges
		send_item(ACT_UNUSED_6, 6'd63, 6'd63);
		send_item(ACT_UNUSED_7, 6'd0, 6'd63);
		send_item(ACT_QUERY, 6'd0, 6'd0);
		send_item(ACT_CLEAR, 6'd0, 6'd0);
		send_item(ACT_QUERY, 6'd0, 6'd0);
		drain();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
			0: md = DIST_MIN;
			1: md = DIST_MAX;
			3: md = DIST_ONE;
			default: md = 6'($urandom_range(0, 63));
			endcase
			pool_span = spans[ph];
			pool_base = $urandom_range(0, NODES - pool_span);
			apb_write(md);
			apb_check_read();
			start_count = items_sent;
			while (items_sent - start_count < PHASE_ITEMS) random_item();
			drain();
		end

		if (sb.fails == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
